// ===== design/fll_pkg.sv =====
package fll_pkg;

	localparam int MAX_ITEMS_DEF = 16;

	typedef struct packed {
		logic [15:0] pref_width;
		logic [15:0] pref_height;
		logic [7:0]  grow_weight;
		logic        last_item;
	} fll_in_t;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] size_w;
		logic [15:0] size_h;
		logic        last_rect;
	} fll_out_t;

	typedef enum logic [2:0] {
		REG_DIR     = 3'd0,
		REG_ALIGN   = 3'd1,
		REG_JUSTIFY = 3'd2,
		REG_GAP     = 3'd3,
		REG_PAD     = 3'd4,
		REG_CW      = 3'd5,
		REG_CH      = 3'd6
	} fll_reg_t;

	localparam logic [1:0] ALIGN_START  = 2'd0;
	localparam logic [1:0] ALIGN_CENTER = 2'd1;
	localparam logic [1:0] ALIGN_END    = 2'd2;
	localparam logic [1:0] ALIGN_STRETCH = 2'd3;
	localparam logic [1:0] JUST_START   = 2'd0;
	localparam logic [1:0] JUST_CENTER  = 2'd1;
	localparam logic [1:0] JUST_END     = 2'd2;
	localparam logic [1:0] JUST_BETWEEN = 2'd3;

	typedef struct packed {
		logic        direction_column;
		logic [1:0]  align_mode;
		logic [1:0]  justify_mode;
		logic [15:0] gap_size;
		logic [15:0] padding_size;
		logic [15:0] box_width;
		logic [15:0] box_height;
	} fll_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_PREP,
		ST_JDIV,
		ST_JWAIT,
		ST_RD,
		ST_GDIV,
		ST_GWAIT,
		ST_SDIV,
		ST_SWAIT,
		ST_EMIT
	} fll_state_t;

	// controller -> datapath
	typedef struct packed {
		logic store;
		logic clr_count;
		logic sum_clr;
		logic sum_step;
		logic prep;
		logic jdiv_go;
		logic jdiv_done;
		logic rd_item;
		logic gdiv_go;
		logic gdiv_done;
		logic sdiv_go;
		logic sdiv_done;
		logic emit;
	} fll_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_last;
		logic have_items;
		logic sum_end;
		logic need_jdiv;
		logic need_gdiv;
		logic need_sdiv;
		logic div_busy;
		logic emit_end;
	} fll_sts_t;

endpackage

// ===== design/fll_div.sv =====
// restoring divider, one quotient bit per cycle
module fll_div import fll_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [39:0] dividend,
	input  logic [23:0] divisor,
	output logic        busy,
	output logic [39:0] quotient
);
	logic [5:0]  cnt_q;
	logic [39:0] q_q;
	logic [24:0] r_q;
	logic [23:0] d_q;
	logic [24:0] r_sh;
	logic [24:0] r_sub;

	assign r_sh = {r_q[23:0], q_q[39]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= 6'd40;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!r_sub[24]) begin
				r_q <= r_sub;
				q_q <= {q_q[38:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[38:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = q_q;
endmodule

// ===== design/fll_ctrl.sv =====
module fll_ctrl import fll_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  fll_sts_t sts,
	output logic     busy,
	output fll_cmd_t cmd
);
	fll_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && sts.is_last) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (!sts.have_items) begin
					state_d = ST_IDLE;
				end else if (sts.sum_end) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: state_d = ST_JDIV;
			ST_JDIV: state_d = sts.need_jdiv ? ST_JWAIT : ST_RD;
			ST_JWAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_GDIV;
			ST_GDIV: state_d = sts.need_gdiv ? ST_GWAIT : ST_SDIV;
			ST_GWAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_SDIV;
				end
			end
			ST_SDIV: state_d = sts.need_sdiv ? ST_SWAIT : ST_EMIT;
			ST_SWAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: state_d = sts.emit_end ? ST_IDLE : ST_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.store = start;
				cmd.sum_clr = start;
			end
			ST_SUM: begin
				cmd.sum_step = sts.have_items;
				cmd.clr_count = !sts.have_items;
			end
			ST_PREP: cmd.prep = 1'b1;
			ST_JDIV: cmd.jdiv_go = sts.need_jdiv;
			ST_JWAIT: cmd.jdiv_done = !sts.div_busy;
			ST_RD: cmd.rd_item = 1'b1;
			ST_GDIV: cmd.gdiv_go = sts.need_gdiv;
			ST_GWAIT: cmd.gdiv_done = !sts.div_busy;
			ST_SDIV: cmd.sdiv_go = sts.need_sdiv;
			ST_SWAIT: cmd.sdiv_done = !sts.div_busy;
			ST_EMIT: begin
				cmd.emit = 1'b1;
				cmd.clr_count = sts.emit_end;
			end
			default: cmd = '0;
		endcase
	end
endmodule

// ===== design/fll_dp.sv =====
module fll_dp import fll_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  fll_in_t  in_item,
	input  fll_cfg_t cfg,
	input  fll_cmd_t cmd,
	output fll_sts_t sts,
	output logic     done,
	output fll_out_t result
);
	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [39:0] mem_q [MAX_ITEMS];
	logic [39:0] rd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] idx_a;
	logic [22:0] pref_tot_q;
	logic [14:0] grow_tot_q;

	logic [17:0] main_q, cross_q;        // avail_main, avail_cross
	logic [24:0] rem_extra_q, rem_over_q, rem_shr_q;
	logic [14:0] rem_grow_q;
	logic [40:0] cursor_q;
	logic [40:0] dgap_q;
	logic [24:0] m_q;
	logic [24:0] m_fin;

	logic        div_go;
	logic [39:0] div_a;
	logic [23:0] div_b;
	logic        div_busy;
	logic [39:0] div_qo;

	logic [15:0] pm, pc;
	logic [7:0]  g;

	logic        jd_q;
	logic        gd_q;
	logic [24:0] extra;
	logic [24:0] s_raw;
	logic [24:0] s_lim;

	assign idx_a = idx_q[IW-1:0];
	assign pm = cfg.direction_column ? rd_q[23:8] : rd_q[39:24];
	assign pc = cfg.direction_column ? rd_q[39:24] : rd_q[23:8];
	assign g = rd_q[7:0];

	// store and read port
	always_ff @(posedge clk) begin
		if (cmd.store && (count_q < CW'(MAX_ITEMS))) begin
			mem_q[count_q[IW-1:0]] <= {in_item.pref_width, in_item.pref_height,
				in_item.grow_weight};
		end
		rd_q <= mem_q[idx_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clr_count) begin
			count_q <= '0;
		end else if (cmd.store && (count_q < CW'(MAX_ITEMS))) begin
			count_q <= count_q + CW'(1);
		end
	end

	// sum pass: address idx_q, data arrives in rd_q on the cycle after
	logic sum_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_v_q <= 1'b0;
		end else if (cmd.sum_clr || cmd.prep) begin
			idx_q <= '0;
			sum_v_q <= 1'b0;
		end else if (cmd.sum_step) begin
			sum_v_q <= (idx_q < count_q);
			if (idx_q < count_q) begin
				idx_q <= idx_q + CW'(1);
			end
		end else if (cmd.emit) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	assign sts.sum_end = !sum_v_q && (idx_q == count_q) && (idx_q != '0);
	assign sts.have_items = (count_q != '0);
	assign sts.is_last = in_item.last_item;
	assign sts.div_busy = div_busy;
	assign sts.emit_end = ((idx_q + CW'(1)) == count_q);

	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			pref_tot_q <= '0;
			grow_tot_q <= '0;
		end else if (cmd.sum_step && sum_v_q) begin
			pref_tot_q <= pref_tot_q + 23'(pm);
			grow_tot_q <= grow_tot_q + 15'(g);
		end
	end

	// container geometry
	logic [17:0] pad2;
	logic [17:0] inner_w, inner_h, inner_m;
	logic [23:0] gap_tot;
	logic [24:0] am_raw;
	logic [17:0] am;
	logic [24:0] lo_raw;
	assign pad2 = {1'b0, cfg.padding_size, 1'b0};
	assign inner_w = (18'(cfg.box_width) > pad2) ? 18'(cfg.box_width) - pad2 : '0;
	assign inner_h = (18'(cfg.box_height) > pad2) ? 18'(cfg.box_height) - pad2 : '0;
	assign inner_m = cfg.direction_column ? inner_h : inner_w;
	assign gap_tot = cfg.gap_size * 8'(count_q - CW'(1));
	assign am_raw = 25'(inner_m) - 25'(gap_tot);
	assign am = am_raw[24] ? '0 : am_raw[17:0];
	assign lo_raw = 25'(main_q) - 25'(pref_tot_q);

	logic nz_grow;
	assign nz_grow = (grow_tot_q != '0);
	assign sts.need_jdiv = !nz_grow && (cfg.justify_mode == JUST_BETWEEN)
		&& (count_q > CW'(1));

	// main_q is loaded in PREP from am; leftover computed the cycle after
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			main_q <= am;
			cross_q <= cfg.direction_column ? inner_w : inner_h;
		end
	end

	logic [23:0] left_c, over_c;
	assign left_c = lo_raw[24] ? '0 : lo_raw[23:0];
	assign over_c = lo_raw[24] ? 24'(-lo_raw) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jd_q <= 1'b0;
		end else begin
			jd_q <= cmd.prep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gd_q <= 1'b0;
		end else begin
			gd_q <= cmd.rd_item;
		end
	end

	// grow / shrink per item
	assign sts.need_gdiv = (g != '0) && (rem_grow_q != '0);
	assign sts.need_sdiv = (rem_over_q != '0) && (rem_shr_q != '0);

	assign extra = div_qo[24:0];
	assign s_raw = (div_qo > 40'(m_q)) ? m_q : div_qo[24:0];
	assign s_lim = s_raw;

	// jd_q marks the JDIV cycle (set up the second pass),
	// gd_q the GDIV cycle, where rd_q is valid
	always_ff @(posedge clk) begin
		if (jd_q) begin
			rem_extra_q <= 25'(left_c);
			rem_over_q <= 25'(over_c);
			rem_shr_q <= 25'(pref_tot_q);
			rem_grow_q <= grow_tot_q;
			dgap_q <= 41'(cfg.gap_size);
			cursor_q <= '0;
			if (!nz_grow) begin
				if (cfg.justify_mode == JUST_CENTER) begin
					cursor_q <= 41'(left_c >> 1);
				end else if (cfg.justify_mode == JUST_END) begin
					cursor_q <= 41'(left_c);
				end
			end
		end else if (cmd.jdiv_done) begin
			dgap_q <= 41'(cfg.gap_size) + 41'(div_qo);
		end else if (gd_q) begin
			m_q <= 25'(pm);
		end else if (cmd.gdiv_done) begin
			m_q <= m_q + extra;
			rem_extra_q <= rem_extra_q - extra;
			rem_grow_q <= rem_grow_q - 15'(g);
		end else if (cmd.sdiv_done) begin
			m_q <= m_q - s_lim;
			rem_over_q <= rem_over_q - s_lim;
		end else if (cmd.emit) begin
			cursor_q <= cursor_q + 41'(m_fin) + dgap_q;
			rem_shr_q <= rem_shr_q - 25'(pm);
		end
	end

	assign div_go = cmd.jdiv_go || cmd.gdiv_go || cmd.sdiv_go;
	always_comb begin
		div_a = '0;
		div_b = 24'd1;
		if (cmd.jdiv_go) begin
			div_a = 40'(left_c);
			div_b = 24'(count_q - CW'(1));
		end else if (cmd.gdiv_go) begin
			div_a = 40'(rem_extra_q) * 40'(g);
			div_b = 24'(rem_grow_q);
		end else if (cmd.sdiv_go) begin
			div_a = 40'(rem_over_q) * 40'(pm);
			div_b = rem_shr_q[23:0];
		end
	end

	fll_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(div_a), .divisor(div_b),
		.busy(div_busy), .quotient(div_qo)
	);

	// output formation
	logic [17:0] c, off;
	logic [41:0] mpos, cpos;
	assign m_fin = m_q;
	always_comb begin
		if (cfg.align_mode == ALIGN_STRETCH || pc == '0) begin
			c = cross_q;
		end else begin
			c = (18'(pc) < cross_q) ? 18'(pc) : cross_q;
		end
		off = '0;
		if (cfg.align_mode == ALIGN_CENTER) begin
			off = (cross_q - c) >> 1;
		end else if (cfg.align_mode == ALIGN_END) begin
			off = cross_q - c;
		end
	end
	assign mpos = 42'(cfg.padding_size) + 42'(cursor_q);
	assign cpos = 42'(cfg.padding_size) + 42'(off);

	function automatic logic [15:0] sat(input logic [41:0] v);
		return (v > 42'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result.last_rect <= sts.emit_end;
			if (cfg.direction_column) begin
				result.pos_x <= sat(cpos);
				result.pos_y <= sat(mpos);
				result.size_w <= sat(42'(c));
				result.size_h <= sat(42'(m_fin));
			end else begin
				result.pos_x <= sat(mpos);
				result.pos_y <= sat(cpos);
				result.size_w <= sat(42'(m_fin));
				result.size_h <= sat(42'(c));
			end
		end
	end
endmodule

// ===== design/flex_line_layout_top.sv =====
// Layout engine for one flex line. Items enter one per start pulse while busy is low; a
// non-last item leaves busy low. On the last item busy stays high for the whole layout:
// a sum pass, the PREP and JDIV setup steps, an optional divider wait for space-between,
// then per item the RD, GDIV, SDIV and EMIT steps plus up to two waits on the shared
// bit-serial divider (grow share, shrink share). Each rectangle appears for one cycle on
// result with done high, the cycle after its emit step; the receiver cannot stall, so it
// must take every done cycle.
module flex_line_layout_top import fll_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  fll_in_t     in_item,
	output logic        busy,
	output logic        done,
	output fll_out_t    result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	fll_cfg_t cfg_q;
	fll_cmd_t cmd;
	fll_sts_t sts;
	logic     ctl_busy;

	assign pready = 1'b1;
	assign busy = ctl_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{direction_column: 1'b0, align_mode: ALIGN_STRETCH, default: '0};
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_DIR:     cfg_q.direction_column <= pwdata[0];
				REG_ALIGN:   cfg_q.align_mode <= pwdata[1:0];
				REG_JUSTIFY: cfg_q.justify_mode <= pwdata[1:0];
				REG_GAP:     cfg_q.gap_size <= pwdata[15:0];
				REG_PAD:     cfg_q.padding_size <= pwdata[15:0];
				REG_CW:      cfg_q.box_width <= pwdata[15:0];
				REG_CH:      cfg_q.box_height <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_DIR:     prdata = 32'(cfg_q.direction_column);
			REG_ALIGN:   prdata = 32'(cfg_q.align_mode);
			REG_JUSTIFY: prdata = 32'(cfg_q.justify_mode);
			REG_GAP:     prdata = 32'(cfg_q.gap_size);
			REG_PAD:     prdata = 32'(cfg_q.padding_size);
			REG_CW:      prdata = 32'(cfg_q.box_width);
			REG_CH:      prdata = 32'(cfg_q.box_height);
			default:     prdata = '0;
		endcase
	end

	fll_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start && !ctl_busy), .sts(sts),
		.busy(ctl_busy), .cmd(cmd)
	);

	fll_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cfg(cfg_q), .cmd(cmd),
		.sts(sts), .done(done), .result(result)
	);
endmodule

// ===== design/fll_checker.sv =====
module fll_checker import fll_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input fll_in_t  in_item,
	input fll_out_t result
);
	// a non-last transfer never raises busy
	a_nonlast_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !in_item.last_item) |=> !busy)
		else $error("busy after non-last item");

	// results only come out of a layout
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without layout");

	// final rectangle ends the layout
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.last_rect) |-> !busy)
		else $error("busy after final rectangle");

	// results are never back to back
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("consecutive results");
endmodule

bind flex_line_layout_top fll_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.in_item(in_item), .result(result)
);
